FILE: hdl/ardo_pkg.sv
package ardo_pkg;

  // Field widths
  localparam int ECHO_W    = 20;
  localparam int TIME_W    = 32;
  localparam int DIST_W    = 15;
  localparam int THR_W     = 15;
  localparam int DWELL_W   = 31;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 2;

  // Width to cm conversion: width * 0.017 in Q16, truncated
  localparam int Q_FRAC    = 16;
  localparam int Q_COEF_W  = 11;
  localparam int MULT_W    = ECHO_W + Q_COEF_W;
  localparam logic [Q_COEF_W-1:0] Q16_FACTOR = 11'd1114;

  // Upper bound on the distance any 20-bit width converts to
  localparam int DIST_MAX  = 17824;

  // Register reset values
  localparam logic [THR_W-1:0]   THRESHOLD_RST = 15'd50;
  localparam logic [DWELL_W-1:0] DWELL_RST     = 31'd5000;
  localparam logic [DWELL_W-1:0] TOGGLE_RST    = 31'd0;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_DWELL     = 2'd1,
    REG_TOGGLE    = 2'd2
  } cfg_reg_t;

endpackage

FILE: hdl/ardo_cell.sv
// One tap of the sample window: holds a distance and passes it on when shifted.
module ardo_cell (
  input  logic                        clk,
  input  logic                        en,
  input  logic [ardo_pkg::DIST_W-1:0] d,
  output logic [ardo_pkg::DIST_W-1:0] q
);

  always_ff @(posedge clk) begin
    if (en) begin
      q <= d;
    end
  end

endmodule

FILE: hdl/ardo_window.sv
// Sample window as a shift line of cells, with fill count, running sum
// and the threshold product for the sample just added.
module ardo_window #(
  parameter int WINDOW = 100
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                shift,
  input  logic [ardo_pkg::DIST_W-1:0]         dist_in,
  input  logic [ardo_pkg::THR_W-1:0]          threshold,
  output logic [ardo_pkg::DIST_W+$clog2(WINDOW+1)-1:0] sum,
  output logic [ardo_pkg::DIST_W+$clog2(WINDOW+1)-1:0] thr_prod
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = ardo_pkg::DIST_W + CNT_W;

  logic [ardo_pkg::DIST_W-1:0] tap [WINDOW+1];
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            count_next;
  logic [SUM_W-1:0]            sum_next;
  logic [SUM_W-1:0]            thr_prod_next;
  logic                        full;

  assign tap[0] = dist_in;

  // Chain of cells; the last tap holds the oldest sample
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    ardo_cell u_cell (
      .clk (clk),
      .en  (shift),
      .d   (tap[i]),
      .q   (tap[i+1])
    );
  end

  // Drop the oldest sample once the window is full
  assign full          = (count == CNT_W'(WINDOW));
  assign count_next    = full ? count : count + 1'b1;
  assign sum_next      = sum - (full ? SUM_W'(tap[WINDOW]) : '0) + SUM_W'(dist_in);
  assign thr_prod_next = SUM_W'(threshold) * SUM_W'(count_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      sum      <= '0;
      thr_prod <= '0;
    end else if (shift) begin
      count    <= count_next;
      sum      <= sum_next;
      thr_prod <= thr_prod_next;
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(WINDOW))
    else $error("window fill count beyond window depth");

  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    32'(sum) <= 32'(count) * ardo_pkg::DIST_MAX)
    else $error("running sum exceeds largest possible window total");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !shift |=> $stable(count) && $stable(sum))
    else $error("window state changed without a shift");
`endif

endmodule

FILE: hdl/averaged_range_occupancy_detector_unit.sv
// Averaged range occupancy detector. Each input transaction carries an echo
// width in microseconds and a millisecond timestamp; each yields exactly one
// output transaction after it passes stage 1, stage 2 and the output register.
// One transaction is accepted every cycle unless the output stalls: the
// running sum in the window cell chain is updated once per sample, and the
// dwell and toggle timers once per sample in the final stage, so neither limits
// throughput. Average-above-threshold is decided as sum > threshold * count,
// so no divider is used. The window needs no clearing pass after reset; only
// filled entries are ever read. Configuration writes must be made while idle.
module averaged_range_occupancy_detector_unit #(
  parameter int WINDOW = 100
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration
  input  logic                                  cfg_write_enable,
  input  logic [ardo_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [ardo_pkg::CFG_W-1:0]            cfg_data,
  // input channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [ardo_pkg::ECHO_W-1:0]           echo_width_us,
  input  logic [ardo_pkg::TIME_W-1:0]           time_ms,
  // output channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [ardo_pkg::DIST_W-1:0]           distance_cm,
  output logic                                  parked,
  output logic                                  beacon_level,
  output logic                                  pins_updated,
  output logic                                  dwell_running
);

  localparam int CNT_W = $clog2(WINDOW + 1);
  localparam int SUM_W = ardo_pkg::DIST_W + CNT_W;

  // Configuration registers
  logic [ardo_pkg::THR_W-1:0]   threshold;
  logic [ardo_pkg::DWELL_W-1:0] dwell_time;
  logic [ardo_pkg::DWELL_W-1:0] toggle_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold       <= ardo_pkg::THRESHOLD_RST;
      dwell_time      <= ardo_pkg::DWELL_RST;
      toggle_interval <= ardo_pkg::TOGGLE_RST;
    end else if (cfg_write_enable) begin
      case (ardo_pkg::cfg_reg_t'(cfg_index))
        ardo_pkg::REG_THRESHOLD: threshold       <= cfg_data[ardo_pkg::THR_W-1:0];
        ardo_pkg::REG_DWELL:     dwell_time      <= cfg_data[ardo_pkg::DWELL_W-1:0];
        ardo_pkg::REG_TOGGLE:    toggle_interval <= cfg_data[ardo_pkg::DWELL_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic s1_valid, s2_valid;
  logic adv1, adv2, adv3;

  assign adv3     = s2_valid && (!out_valid || !out_stall);
  assign adv2     = s1_valid && (!s2_valid || adv3);
  assign adv1     = in_valid && (!s1_valid || adv2);
  assign in_stall = s1_valid && !adv2;

  // Stage 1: width to distance
  logic [ardo_pkg::MULT_W-1:0] echo_mult;
  logic [ardo_pkg::DIST_W-1:0] s1_dist;
  logic [ardo_pkg::TIME_W-1:0] s1_time;
  logic                        s1_test;
  logic                        test_mode;

  assign test_mode = (toggle_interval != '0);
  assign echo_mult = ardo_pkg::MULT_W'(echo_width_us) * ardo_pkg::MULT_W'(ardo_pkg::Q16_FACTOR);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv1) begin
      s1_valid <= 1'b1;
    end else if (adv2) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s1_dist <= test_mode ? '0 : echo_mult[ardo_pkg::Q_FRAC +: ardo_pkg::DIST_W];
      s1_time <= time_ms;
      s1_test <= test_mode;
    end
  end

  // Stage 2: window shift, running sum and threshold product
  logic [SUM_W-1:0]            win_sum;
  logic [SUM_W-1:0]            win_thr_prod;
  logic [ardo_pkg::DIST_W-1:0] s2_dist;
  logic [ardo_pkg::TIME_W-1:0] s2_time;
  logic                        s2_test;

  ardo_window #(
    .WINDOW (WINDOW)
  ) u_window (
    .clk       (clk),
    .rst       (rst),
    .shift     (adv2 && !s1_test),
    .dist_in   (s1_dist),
    .threshold (threshold),
    .sum       (win_sum),
    .thr_prod  (win_thr_prod)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv2) begin
      s2_valid <= 1'b1;
    end else if (adv3) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv2) begin
      s2_dist <= s1_dist;
      s2_time <= s1_time;
      s2_test <= s1_test;
    end
  end

  // Stage 3: presence, dwell timer and test toggle
  logic                        parked_flag, parked_flag_next;
  logic                        dwell_active, dwell_active_next;
  logic [ardo_pkg::TIME_W-1:0] dwell_start, dwell_start_next;
  logic                        toggle_armed, toggle_armed_next;
  logic [ardo_pkg::TIME_W-1:0] toggle_start, toggle_start_next;
  logic                        updated;
  logic                        above;
  logic [ardo_pkg::TIME_W-1:0] dwell_elapsed;
  logic [ardo_pkg::TIME_W-1:0] toggle_elapsed;

  assign above          = (win_sum > win_thr_prod);
  assign dwell_elapsed  = s2_time - dwell_start;
  assign toggle_elapsed = s2_time - toggle_start;

  always_comb begin
    parked_flag_next  = parked_flag;
    dwell_active_next = dwell_active;
    dwell_start_next  = dwell_start;
    toggle_armed_next = toggle_armed;
    toggle_start_next = toggle_start;
    updated           = 1'b0;
    if (s2_test) begin
      if (!toggle_armed) begin
        toggle_armed_next = 1'b1;
        toggle_start_next = s2_time;
      end else if (toggle_elapsed > {1'b0, toggle_interval}) begin
        parked_flag_next  = !parked_flag;
        toggle_start_next = s2_time;
        updated           = 1'b1;
      end
    end else begin
      if (above) begin
        if (parked_flag || dwell_active) begin
          parked_flag_next  = 1'b0;
          dwell_active_next = 1'b0;
          dwell_start_next  = '0;
          updated           = 1'b1;
        end
      end else if (!dwell_active) begin
        dwell_active_next = 1'b1;
        dwell_start_next  = s2_time;
      end
      // timer just started has zero elapsed time
      if (dwell_active_next && !parked_flag_next) begin
        if (dwell_active ? (dwell_elapsed >= {1'b0, dwell_time}) : (dwell_time == '0)) begin
          parked_flag_next = 1'b1;
          updated          = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parked_flag  <= 1'b0;
      dwell_active <= 1'b0;
      dwell_start  <= '0;
      toggle_armed <= 1'b0;
      toggle_start <= '0;
    end else if (adv3) begin
      parked_flag  <= parked_flag_next;
      dwell_active <= dwell_active_next;
      dwell_start  <= dwell_start_next;
      toggle_armed <= toggle_armed_next;
      toggle_start <= toggle_start_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv3) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv3) begin
      distance_cm   <= s2_dist;
      parked        <= parked_flag_next;
      beacon_level  <= !parked_flag_next;
      pins_updated  <= updated;
      dwell_running <= dwell_active_next;
    end
  end

`ifndef SYNTH
  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv2 |=> s1_valid && $stable(s1_time) && $stable(s1_dist))
    else $error("stage 1 transaction lost while blocked");

  a_test_keeps_dwell: assert property (@(posedge clk) disable iff (rst)
    adv3 && s2_test |=> $stable(dwell_active) && $stable(dwell_start))
    else $error("test mode transaction disturbed the dwell timer");
`endif

endmodule
